### hdl/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

   localparam int SIZE_LINE_BYTES = 16;

   localparam int DATA_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DATA_W-1:0] BODY_CAPACITY_RESET = 32'd4096;
   localparam logic [DATA_W-1:0] LINE_END_BYTES      = 32'd2;

   localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;

   // register index taken from paddr[2]
   localparam logic REG_BODY_CAPACITY = 1'b0;

   typedef enum logic {
      FUNC_DATA    = 1'b0,
      FUNC_RESTART = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      PH_SIZE  = 3'd0,
      PH_DATA  = 3'd1,
      PH_AFTER = 3'd2,
      PH_DONE  = 3'd3,
      PH_ERROR = 3'd4
   } phase_type;

   typedef struct packed {
      logic              store_valid;
      logic [BYTE_W-1:0] store_byte;
      logic [DATA_W-1:0] store_offset;
      logic              dropped;
      logic              parse_error;
      logic              finished;
   } result_type;

   typedef struct packed {
      phase_type phase;
      logic      restart;
   } status_type;

   // bit 4 set when the byte is a hex digit, low nibble is its value
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
      logic [4:0] v;
      v = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = {1'b1, 4'(b - 8'h37)};
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### hdl/hcbd_if.sv
`default_nettype none

interface hcbd_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [hcbd_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface hcbd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      store_valid;
   logic [hcbd_pkg::BYTE_W-1:0] store_byte;
   logic [hcbd_pkg::DATA_W-1:0] store_offset;
   logic                      dropped;
   logic                      parse_error;
   logic                      finished;

   modport source (output valid, output store_valid, output store_byte,
                   output store_offset, output dropped, output parse_error,
                   output finished, input ready);
   modport sink   (input valid, input store_valid, input store_byte,
                   input store_offset, input dropped, input parse_error,
                   input finished, output ready);
endinterface

`default_nettype wire

### hdl/hcbd_csr.sv
`default_nettype none

module hcbd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [hcbd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [hcbd_pkg::DATA_W-1:0]       pwdata,
   output logic      [hcbd_pkg::DATA_W-1:0]       prdata,
   output logic                                   pready,
   output logic      [hcbd_pkg::DATA_W-1:0]       body_capacity
);

   logic                          capacity_sel;
   logic [hcbd_pkg::DATA_W-1:0]   capacity_ff;
   logic [hcbd_pkg::DATA_W-1:0]   capacity_in;

   assign capacity_sel = (paddr[2] == hcbd_pkg::REG_BODY_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && capacity_sel) begin
         capacity_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= hcbd_pkg::BODY_CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata        = capacity_sel ? capacity_ff : '0;
   assign pready        = 1'b1;
   assign body_capacity = capacity_ff;

endmodule

`default_nettype wire

### hdl/hcbd_core.sv
`default_nettype none

module hcbd_core #(
   parameter int SIZE_LINE_BYTES = hcbd_pkg::SIZE_LINE_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step_en,
   input  wire logic                            func,
   input  wire logic [hcbd_pkg::BYTE_W-1:0]     data_byte,
   input  wire logic [hcbd_pkg::DATA_W-1:0]     body_capacity,
   output hcbd_pkg::result_type                 result,
   output hcbd_pkg::status_type                 status
);

   localparam int LcW = $clog2(SIZE_LINE_BYTES);
   localparam logic [LcW:0] LineLimit = (LcW+1)'(SIZE_LINE_BYTES);

   hcbd_pkg::phase_type          phase_ff, phase_in;
   logic [hcbd_pkg::DATA_W-1:0]  remaining_ff, remaining_in;
   logic                         last_chunk_ff, last_chunk_in;
   logic [LcW-1:0]               line_count_ff, line_count_in;
   logic [hcbd_pkg::DATA_W-1:0]  size_accum_ff, size_accum_in;
   logic                         ext_seen_ff, ext_seen_in;
   logic                         bad_digit_ff, bad_digit_in;
   logic [hcbd_pkg::DATA_W-1:0]  body_count_ff, body_count_in;

   logic [4:0]                   hv;
   logic [LcW:0]                 line_next;
   logic [hcbd_pkg::DATA_W-1:0]  rem_dec;

   assign hv        = hcbd_pkg::hex_value(data_byte);
   assign line_next = {1'b0, line_count_ff} + 1'b1;
   assign rem_dec   = (remaining_ff == '0) ? '0 : remaining_ff - 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      last_chunk_in = last_chunk_ff;
      line_count_in = line_count_ff;
      size_accum_in = size_accum_ff;
      ext_seen_in   = ext_seen_ff;
      bad_digit_in  = bad_digit_ff;
      body_count_in = body_count_ff;
      result        = '0;

      if (func == hcbd_pkg::FUNC_RESTART) begin
         phase_in      = hcbd_pkg::PH_SIZE;
         remaining_in  = '0;
         last_chunk_in = 1'b0;
         line_count_in = '0;
         size_accum_in = '0;
         ext_seen_in   = 1'b0;
         bad_digit_in  = 1'b0;
         body_count_in = '0;
      end else begin
         case (phase_ff)
            hcbd_pkg::PH_SIZE: begin
               if (data_byte == hcbd_pkg::CHAR_LF) begin
                  if (bad_digit_ff) begin
                     phase_in = hcbd_pkg::PH_ERROR;
                  end else begin
                     line_count_in = '0;
                     size_accum_in = '0;
                     ext_seen_in   = 1'b0;
                     bad_digit_in  = 1'b0;
                     last_chunk_in = (size_accum_ff == '0);
                     if (size_accum_ff == '0) begin
                        remaining_in = hcbd_pkg::LINE_END_BYTES;
                        phase_in     = hcbd_pkg::PH_AFTER;
                     end else begin
                        remaining_in = size_accum_ff;
                        phase_in     = hcbd_pkg::PH_DATA;
                     end
                  end
               end else if (data_byte != hcbd_pkg::CHAR_CR) begin
                  if (line_next >= LineLimit) begin
                     phase_in = hcbd_pkg::PH_ERROR;
                  end else begin
                     line_count_in = line_next[LcW-1:0];
                     // everything after ';' is chunk extension
                     if (!ext_seen_ff) begin
                        if (data_byte == hcbd_pkg::CHAR_SEMI) begin
                           ext_seen_in = 1'b1;
                        end else if (!hv[4]) begin
                           bad_digit_in = 1'b1;
                        end else begin
                           size_accum_in = {size_accum_ff[hcbd_pkg::DATA_W-5:0], hv[3:0]};
                        end
                     end
                  end
               end
            end
            hcbd_pkg::PH_DATA: begin
               if (body_count_ff < body_capacity) begin
                  result.store_valid  = 1'b1;
                  result.store_byte   = data_byte;
                  result.store_offset = body_count_ff;
                  body_count_in       = body_count_ff + 1'b1;
               end else begin
                  result.dropped = 1'b1;
               end
               remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  remaining_in = hcbd_pkg::LINE_END_BYTES;
                  phase_in     = hcbd_pkg::PH_AFTER;
               end
            end
            hcbd_pkg::PH_AFTER: begin
               if (data_byte != hcbd_pkg::CHAR_CR && data_byte != hcbd_pkg::CHAR_LF) begin
                  phase_in = hcbd_pkg::PH_ERROR;
               end else begin
                  remaining_in = rem_dec;
                  if (rem_dec == '0) begin
                     phase_in = last_chunk_ff ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_SIZE;
                  end
               end
            end
            default: begin
               // done and error hold until restart
            end
         endcase
      end

      result.parse_error = (phase_in == hcbd_pkg::PH_ERROR);
      result.finished    = (phase_in == hcbd_pkg::PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hcbd_pkg::PH_SIZE;
         remaining_ff  <= '0;
         last_chunk_ff <= 1'b0;
         line_count_ff <= '0;
         size_accum_ff <= '0;
         ext_seen_ff   <= 1'b0;
         bad_digit_ff  <= 1'b0;
         body_count_ff <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         last_chunk_ff <= last_chunk_in;
         line_count_ff <= line_count_in;
         size_accum_ff <= size_accum_in;
         ext_seen_ff   <= ext_seen_in;
         bad_digit_ff  <= bad_digit_in;
         body_count_ff <= body_count_in;
      end
   end

   assign status.phase   = phase_ff;
   assign status.restart = step_en && (func == hcbd_pkg::FUNC_RESTART);

endmodule

`default_nettype wire

### hdl/http_chunked_body_decoder_top.sv
`default_nettype none

// Decodes an HTTP/1.1 chunked body one byte per word: each accepted request
// word yields exactly one response word carrying the payload write (byte and
// body offset), a dropped flag when the body buffer is full, and sticky
// parse_error / finished flags that hold until a restart word. A new word is
// taken every cycle while rsp.ready keeps the result register draining; a
// word accepted on req passes through the input register, then the result
// register, before its response shows on rsp; the rate is set by the update
// of the decoder state in the core. body_capacity sits at byte address 0 of
// the APB port and should only be written while idle.
module http_chunked_body_decoder_top #(
   parameter int SIZE_LINE_BYTES = hcbd_pkg::SIZE_LINE_BYTES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   hcbd_req_if.sink                               req,
   hcbd_rsp_if.source                             rsp,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [hcbd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [hcbd_pkg::DATA_W-1:0]       pwdata,
   output logic      [hcbd_pkg::DATA_W-1:0]       prdata,
   output logic                                   pready
);

   logic [hcbd_pkg::DATA_W-1:0]  body_capacity;

   logic                         in_valid_ff, in_valid_in;
   logic                         in_func_ff;
   logic [hcbd_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   hcbd_pkg::result_type         result_ff;
   hcbd_pkg::result_type         step_result;
   hcbd_pkg::status_type         core_status;
   logic                         advance;
   logic                         req_fire;

   hcbd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .body_capacity (body_capacity)
   );

   // a word moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff <= req.func;
         in_byte_ff <= req.data_byte;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   hcbd_core #(
      .SIZE_LINE_BYTES (SIZE_LINE_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .func          (in_func_ff),
      .data_byte     (in_byte_ff),
      .body_capacity (body_capacity),
      .result        (step_result),
      .status        (core_status)
   );

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.store_valid  = result_ff.store_valid;
   assign rsp.store_byte   = result_ff.store_byte;
   assign rsp.store_offset = result_ff.store_offset;
   assign rsp.dropped      = result_ff.dropped;
   assign rsp.parse_error  = result_ff.parse_error;
   assign rsp.finished     = result_ff.finished;

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (core_status.phase == hcbd_pkg::PH_ERROR && !core_status.restart)
      |=> core_status.phase == hcbd_pkg::PH_ERROR)
      else $error("error phase left without restart");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (core_status.phase == hcbd_pkg::PH_DONE && !core_status.restart)
      |=> core_status.phase == hcbd_pkg::PH_DONE)
      else $error("done phase left without restart");

   a_store_or_drop: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.store_valid && rsp.dropped))
      else $error("payload word both stored and dropped");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.store_valid) |-> rsp.store_offset < body_capacity)
      else $error("store offset beyond body capacity");

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import hcbd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {REG_BODY_CAPACITY, 2'b00};
   localparam int unsigned WORDS_PER_SETTING = 305;
   localparam int unsigned REPORT_LIMIT = 10;

   class decode_scoreboard;
      result_type pending_results[$];
      logic [DATA_W-1:0] capacity;
      phase_type         phase;
      logic [DATA_W-1:0] chunk_left;
      bit                zero_chunk;
      int unsigned       kept_bytes;
      logic [DATA_W-1:0] size_value;
      bit                in_extension;
      bit                saw_bad_digit;
      logic [DATA_W-1:0] body_bytes;
      int unsigned mismatches, checked, live_words, stores, drops;
      int unsigned framing_errors, bodies_done;

      function new();
         capacity = BODY_CAPACITY_RESET;
         restart_decoder();
      endfunction

      function void restart_decoder();
         phase = PH_SIZE;
         chunk_left = '0;
         zero_chunk = 1'b0;
         kept_bytes = 0;
         size_value = '0;
         in_extension = 1'b0;
         saw_bad_digit = 1'b0;
         body_bytes = '0;
      endfunction

      function int nibble_of(logic [BYTE_W-1:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "a" && c <= "f") return 10 + int'(c - "a");
         if (c >= "A" && c <= "F") return 10 + int'(c - "A");
         return -1;
      endfunction

      function bit is_idle();
         return pending_results.size() == 0;
      endfunction

      // work out the result word for one accepted request word
      function void note_word(func_type f, logic [BYTE_W-1:0] b);
         result_type r;
         phase_type  old_phase;
         int         nib;
         r = '0;
         old_phase = phase;
         if (f == FUNC_RESTART || (phase != PH_DONE && phase != PH_ERROR)) live_words++;
         if (f == FUNC_RESTART) begin
            restart_decoder();
         end else begin
            case (phase)
               PH_SIZE: begin
                  if (b == CHAR_LF) begin
                     if (saw_bad_digit) begin
                        phase = PH_ERROR;
                     end else begin
                        zero_chunk = (size_value == 0);
                        if (size_value == 0) begin
                           chunk_left = LINE_END_BYTES;
                           phase = PH_AFTER;
                        end else begin
                           chunk_left = size_value;
                           phase = PH_DATA;
                        end
                        kept_bytes = 0;
                        size_value = '0;
                        in_extension = 1'b0;
                        saw_bad_digit = 1'b0;
                     end
                  end else if (b != CHAR_CR) begin
                     if (kept_bytes + 1 >= SIZE_LINE_BYTES) begin
                        phase = PH_ERROR;
                     end else begin
                        kept_bytes++;
                        if (!in_extension) begin
                           if (b == CHAR_SEMI) begin
                              in_extension = 1'b1;
                           end else begin
                              nib = nibble_of(b);
                              if (nib < 0) saw_bad_digit = 1'b1;
                              else size_value = (size_value << 4) + DATA_W'(nib);
                           end
                        end
                     end
                  end
               end
               PH_DATA: begin
                  if (body_bytes < capacity) begin
                     r.store_valid = 1'b1;
                     r.store_byte = b;
                     r.store_offset = body_bytes;
                     body_bytes++;
                     stores++;
                  end else begin
                     r.dropped = 1'b1;
                     drops++;
                  end
                  if (chunk_left != 0) chunk_left--;
                  if (chunk_left == 0) begin
                     chunk_left = LINE_END_BYTES;
                     phase = PH_AFTER;
                  end
               end
               PH_AFTER: begin
                  if (b != CHAR_CR && b != CHAR_LF) begin
                     phase = PH_ERROR;
                  end else begin
                     if (chunk_left != 0) chunk_left--;
                     if (chunk_left == 0) phase = zero_chunk ? PH_DONE : PH_SIZE;
                  end
               end
               default: ;
            endcase
         end
         r.parse_error = (phase == PH_ERROR);
         r.finished = (phase == PH_DONE);
         if (phase == PH_ERROR && old_phase != PH_ERROR) framing_errors++;
         if (phase == PH_DONE && old_phase != PH_DONE) bodies_done++;
         pending_results.push_back(r);
      endfunction

      function void check_word(result_type got);
         result_type exp;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("extra result word: valid=%0b byte=%02h offset=%08h drop=%0b err=%0b done=%0b",
                        got.store_valid, got.store_byte, got.store_offset, got.dropped,
                        got.parse_error, got.finished);
            return;
         end
         exp = pending_results.pop_front();
         checked++;
         if (got.store_valid !== exp.store_valid || got.store_byte !== exp.store_byte ||
             got.store_offset !== exp.store_offset || got.dropped !== exp.dropped ||
             got.parse_error !== exp.parse_error || got.finished !== exp.finished) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("mismatch on word %0d", checked);
               $display("  expected valid=%0b byte=%02h offset=%08h drop=%0b err=%0b done=%0b",
                        exp.store_valid, exp.store_byte, exp.store_offset, exp.dropped,
                        exp.parse_error, exp.finished);
               $display("  actual   valid=%0b byte=%02h offset=%08h drop=%0b err=%0b done=%0b",
                        got.store_valid, got.store_byte, got.store_offset, got.dropped,
                        got.parse_error, got.finished);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   hcbd_req_if req_bus ();
   hcbd_rsp_if rsp_bus ();

   decode_scoreboard sb = new();
   bit steady_send = 1'b0;
   bit steady_take = 1'b0;
   int unsigned capacity_writes = 0;

   http_chunked_body_decoder_top uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_word(input func_type f, input logic [BYTE_W-1:0] b);
      int unsigned gap;
      gap = steady_send ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= f;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_word(f, b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(FUNC_DATA, s.getc(i));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (!sb.is_idle()) @(posedge clock);
      // let the bus sit quiet before anything else happens
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAPACITY_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.capacity = value;
      capacity_writes++;
   endtask

   function automatic logic [DATA_W-1:0] pick_size();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
   endfunction

   task automatic send_line_end();
      repeat (2) send_word(FUNC_DATA, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic send_size_line(input logic [DATA_W-1:0] size);
      string digits;
      int unsigned pad, ext_len;
      logic [BYTE_W-1:0] c;
      // ten digits wrap the 32-bit size back down to the real value
      if (size != 0 && $urandom_range(0, 9) == 0) begin
         digits = $sformatf("%h%h%08h", 4'($urandom_range(1, 15)), 4'($urandom_range(0, 15)),
                            size);
      end else begin
         digits = $sformatf("%0h", size);
         pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         repeat (pad) digits = {"0", digits};
      end
      for (int i = 0; i < digits.len(); i++) begin
         c = digits.getc(i);
         if (c >= "a" && $urandom_range(0, 1)) c = c - 8'd32;
         send_word(FUNC_DATA, c);
      end
      // extension stays short enough to keep the line legal
      if (digits.len() < 14 && $urandom_range(0, 3) == 0) begin
         ext_len = $urandom_range(0, 14 - digits.len());
         send_word(FUNC_DATA, CHAR_SEMI);
         repeat (ext_len) begin
            do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
            send_word(FUNC_DATA, c);
         end
      end
      case ($urandom_range(0, 3))
         0: send_word(FUNC_DATA, CHAR_LF);
         1: send_text("\r\r\n");
         default: send_text("\r\n");
      endcase
   endtask

   task automatic send_chunk(input logic [DATA_W-1:0] size);
      send_size_line(size);
      repeat (size) send_word(FUNC_DATA, 8'($urandom_range(0, 255)));
      send_line_end();
   endtask

   task automatic send_body();
      logic [BYTE_W-1:0] c;
      logic [DATA_W-1:0] size;
      send_word(FUNC_RESTART, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) steady_send = !steady_send;
      if ($urandom_range(0, 9) >= 2) begin
         repeat ($urandom_range(1, 4)) send_chunk(pick_size());
         send_size_line('0);
         send_line_end();
         // trailing bytes after the end are ignored
         repeat ($urandom_range(0, 2)) send_word(FUNC_DATA, 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) send_chunk(pick_size());
         case ($urandom_range(0, 3))
            0: begin
               do c = 8'($urandom_range(0, 255));
               while (sb.nibble_of(c) >= 0 || c == CHAR_SEMI || c == CHAR_CR || c == CHAR_LF);
               send_word(FUNC_DATA, c);
               send_text("5\n");
            end
            1: repeat ($urandom_range(16, 18)) send_word(FUNC_DATA, "0");
            2: begin
               size = $urandom_range(1, 16);
               send_size_line(size);
               repeat (size) send_word(FUNC_DATA, 8'($urandom_range(0, 255)));
               do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR || c == CHAR_LF);
               send_word(FUNC_DATA, c);
            end
            default: repeat ($urandom_range(8, 30)) send_word(FUNC_DATA, 8'($urandom_range(0, 255)));
         endcase
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
   endtask

   // result side: random stalls, with stretches of none
   initial begin
      int unsigned stall, taken;
      result_type got;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady_take ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.store_valid = rsp_bus.store_valid;
         got.store_byte = rsp_bus.store_byte;
         got.store_offset = rsp_bus.store_offset;
         got.dropped = rsp_bus.dropped;
         got.parse_error = rsp_bus.parse_error;
         got.finished = rsp_bus.finished;
         sb.check_word(got);
         taken++;
         if (taken % 48 == 0) steady_take = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      logic [DATA_W-1:0] capacities [6];
      capacities = '{32'd1, 32'hFFFF_FFFF, 32'd7, 32'd64, BODY_CAPACITY_RESET, 32'd0};
      capacities[5] = $urandom_range(2, 300);
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_DATA;
      req_bus.data_byte <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extension, byte extremes, bad line end, bad digit, zero chunk, ignored tail
      send_word(FUNC_RESTART, 8'hFF);
      send_text("2;q\r\n");
      send_word(FUNC_DATA, 8'h00);
      send_word(FUNC_DATA, 8'hFF);
      send_text("\r\n1\nAX0");
      send_word(FUNC_RESTART, 8'h00);
      send_text("G\na");
      send_word(FUNC_RESTART, 8'h5A);
      send_text("0\n\n\ra");
      wait_drained();

      foreach (capacities[k]) begin
         write_capacity(capacities[k]);
         while (sb.live_words < 25 + WORDS_PER_SETTING * (k + 1)) send_body();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("covered %0d live words over %0d capacity settings: %0d stores, %0d drops",
               sb.live_words, capacity_writes, sb.stores, sb.drops);
      $display("bodies completed %0d, framing errors %0d, result words checked %0d",
               sb.bodies_done, sb.framing_errors, sb.checked);
      if (sb.mismatches == 0 && sb.is_idle()) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### sim.f
hdl/hcbd_pkg.sv
hdl/hcbd_if.sv
hdl/hcbd_csr.sv
hdl/hcbd_core.sv
hdl/http_chunked_body_decoder_top.sv
verif/tb.sv
